// File: design/gpem_pkg.sv
package gpem_pkg;

	localparam int AXES = 4;
	localparam int DEF_STD_BUTTONS = 12;
	localparam int DEF_XIN_BUTTONS = 10;
	localparam int MAX_EVENTS = AXES + 16 + 1 + 1;
	localparam int TW = $clog2(MAX_EVENTS + 1);

	localparam int PCT_SCALE = 10000;
	localparam int HAT_STEP = 4500;
	localparam int BUTTON_ON = 'h80;
	localparam int TRIG_HIGH = 32767;
	localparam int TRIG_LOW = -32768;
	localparam int TRIG_HIGH_BIT = 10;
	localparam int TRIG_LOW_BIT = 11;

	localparam int IN_W = 88;
	localparam int OUT_W = 56;

	// Operand widths of the shared multiply-divide unit.
	localparam int MD_AW = 24;
	localparam int MD_BW = 19;
	localparam int MD_CW = 24;
	localparam int MD_PW = MD_AW + MD_BW;
	localparam int MD_QW = MD_PW + 1;
	localparam int MD_NW = $clog2(MD_PW + 1);

	typedef enum logic [1:0] {
		EV_AXIS   = 2'd0,
		EV_BUTTON = 2'd1,
		EV_HAT    = 2'd2
	} ev_kind_t;

	typedef enum logic [2:0] {
		REG_MODE       = 3'd0,
		REG_LOG_LOW    = 3'd1,
		REG_LOG_HIGH   = 3'd2,
		REG_OUT_LOW    = 3'd3,
		REG_OUT_HIGH   = 3'd4,
		REG_DEAD_ZONE  = 3'd5,
		REG_SATURATION = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] logical_low;
		logic [14:0]        logical_high;
		logic signed [16:0] output_low;
		logic signed [16:0] output_high;
		logic [13:0]        dead_zone;
		logic [13:0]        saturation_point;
	} cfg_t;

	typedef struct packed {
		logic                    start;
		logic signed [MD_AW-1:0] a;
		logic signed [MD_BW-1:0] b;
		logic signed [MD_CW-1:0] c;
	} md_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [MD_QW-1:0] q;
	} md_rsp_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_ADD,
		MD_DIV
	} md_state_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_AXIS,
		C_DZ_GO,
		C_DZ_WAIT,
		C_SAT_GO,
		C_SAT_WAIT,
		C_CMP,
		C_DIV_WAIT,
		C_BTN,
		C_TRIG,
		C_TRIG_WAIT,
		C_HAT,
		C_EMIT
	} ctrl_state_t;

	function automatic logic [3:0] remap_std(input logic [3:0] i);
		logic [3:0] r;
		case (i)
			4'd0: r = 4'd1;
			4'd1: r = 4'd2;
			4'd2: r = 4'd0;
			4'd3: r = 4'd3;
			4'd4: r = 4'd4;
			4'd5: r = 4'd5;
			4'd6: r = 4'd8;
			4'd7: r = 4'd9;
			4'd8: r = 4'd10;
			4'd9: r = 4'd11;
			4'd10: r = 4'd6;
			4'd11: r = 4'd7;
			default: r = i;
		endcase
		return r;
	endfunction

endpackage

// File: design/gpem_muldiv.sv
// Computes a*b/c rounded half away from zero: one multiply, then a
// restoring divider that produces one quotient bit per cycle.
module gpem_muldiv import gpem_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	md_state_t st_q, st_d;

	logic signed [MD_AW-1:0] a_q;
	logic signed [MD_BW-1:0] b_q;
	logic [MD_CW-1:0]        c_q;
	logic signed [MD_PW-1:0] prod_q;
	logic                    neg_q;
	logic [MD_PW-1:0]        dvd_q;
	logic [MD_CW-1:0]        rem_q;
	logic [MD_NW-1:0]        cnt_q;
	logic                    done_q;

	logic [MD_PW-1:0] mag;
	logic [MD_CW:0]   rem_sh;
	logic [MD_CW:0]   diff;

	assign mag = neg_q ? MD_PW'(-prod_q) : MD_PW'(prod_q);
	assign rem_sh = {rem_q, dvd_q[MD_PW-1]};
	assign diff = rem_sh - {1'b0, c_q};

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			MD_IDLE: if (req.start) st_d = MD_MUL;
			MD_MUL: st_d = MD_ADD;
			MD_ADD: st_d = MD_DIV;
			MD_DIV: if (cnt_q == MD_NW'(1)) st_d = MD_IDLE;
			default: st_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MD_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			done_q <= (st_q == MD_DIV) && (cnt_q == MD_NW'(1));
			if (st_q == MD_ADD) cnt_q <= MD_NW'(MD_PW);
			else if (st_q == MD_DIV) cnt_q <= cnt_q - MD_NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			MD_IDLE: begin
				// A negative divisor moves its sign onto the first factor.
				a_q <= req.c[MD_CW-1] ? -req.a : req.a;
				c_q <= req.c[MD_CW-1] ? MD_CW'(-req.c) : MD_CW'(req.c);
				b_q <= req.b;
			end
			MD_MUL: begin
				prod_q <= MD_PW'(a_q) * MD_PW'(b_q);
				neg_q <= a_q[MD_AW-1] ^ b_q[MD_BW-1];
			end
			MD_ADD: begin
				dvd_q <= mag + MD_PW'(c_q >> 1);
				rem_q <= '0;
			end
			MD_DIV: begin
				if (!diff[MD_CW]) begin
					rem_q <= diff[MD_CW-1:0];
					dvd_q <= {dvd_q[MD_PW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[MD_CW-1:0];
					dvd_q <= {dvd_q[MD_PW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.q = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

endmodule

// File: design/gpem_ctrl.sv
module gpem_ctrl import gpem_pkg::*; #(
	parameter int STD_BUTTONS = DEF_STD_BUTTONS,
	parameter int XIN_BUTTONS = DEF_XIN_BUTTONS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tlast,
	output md_req_t          md_req,
	input  md_rsp_t          md_rsp
);

	localparam int VW = 20;

	ctrl_state_t state_q, state_d, ret_q;

	logic [15:0]        prev_ax_q [AXES];
	logic [15:0]        prev_btn_q;
	logic [3:0]         prev_hat_q;
	logic [31:0]        count_q;
	logic [AXES-1:0]    chg_q;
	logic               btn_chg_q;
	logic               hat_chg_q;
	logic [TW-1:0]      total_q;
	logic [TW-1:0]      sent_q;
	logic [2:0]         idx_q;
	logic [4:0]         bidx_q;
	logic               m_valid_q;

	logic signed [15:0]       item_ax_q [AXES];
	logic [15:0]              btn_q;
	logic [3:0]               hat_q;
	logic [31:0]              seq_q;
	logic signed [VW-1:0]     v_q;
	logic                     side_q;
	logic signed [MD_AW-1:0]  dzv_q;
	logic signed [MD_AW-1:0]  satv_q;
	logic [1:0]               ev_kind_q;
	logic [3:0]               ev_inst_q;
	logic [16:0]              ev_val_q;
	logic [1:0]               m_kind_q;
	logic [3:0]               m_inst_q;
	logic [16:0]              m_val_q;
	logic [31:0]              m_seq_q;
	logic                     m_last_q;

	logic [15:0]          in_ax [AXES];
	logic [AXES-1:0]      in_chg;
	logic                 in_btn_chg;
	logic                 in_hat_chg;
	logic [TW-1:0]        in_total;
	logic                 xin;
	logic [4:0]           nb;
	logic signed [17:0]   lh_s;
	logic signed [17:0]   s_l;
	logic signed [17:0]   s_p;
	logic signed [17:0]   lc;
	logic signed [17:0]   pc;
	logic signed [VW-1:0] v_new;
	logic signed [VW-1:0] side_a;
	logic signed [MD_AW-1:0] lmin;
	logic signed [MD_AW-1:0] lmax;
	logic signed [17:0]   pmin;
	logic signed [17:0]   pmax;
	logic                 cmp_low;
	logic                 cmp_high;
	logic signed [16:0]   raw;
	logic signed [17:0]   lin_d;
	logic signed [MD_QW:0] lin_r;
	logic signed [MD_QW:0] ax_r;
	logic                 out_free;
	logic                 out_load;

	assign xin = cfg.mode;
	assign nb = xin ? 5'(XIN_BUTTONS) : 5'(STD_BUTTONS);

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			in_ax[i] = s_tdata[16*i +: 16];
			in_chg[i] = in_ax[i] != prev_ax_q[i];
		end
	end
	assign in_btn_chg = s_tdata[79:64] != prev_btn_q;
	assign in_hat_chg = s_tdata[83:80] != prev_hat_q;
	assign in_total = TW'(in_chg[0]) + TW'(in_chg[1]) + TW'(in_chg[2]) + TW'(in_chg[3])
		+ (in_btn_chg ? (xin ? TW'(XIN_BUTTONS + 1) : TW'(STD_BUTTONS)) : TW'(0))
		+ TW'(in_hat_chg);

	// Centres of the logical and output ranges.
	assign lh_s = 18'($signed({1'b0, cfg.logical_high}));
	assign s_l = 18'(cfg.logical_low) + lh_s;
	assign s_p = 18'(cfg.output_low) + 18'(cfg.output_high);
	assign lc = (cfg.logical_low == 16'sd0) ? (lh_s >>> 1)
		: (s_l >= 18'sd0 ? ((s_l + 18'sd1) >>> 1) : (s_l >>> 1));
	assign pc = (cfg.output_low == 17'sd0) ? (18'(cfg.output_high) >>> 1)
		: (s_p >= 18'sd0 ? ((s_p + 18'sd1) >>> 1) : (s_p >>> 1));

	assign v_new = VW'(item_ax_q[idx_q[1:0]]) - VW'(lc);
	assign side_a = side_q ? VW'(cfg.logical_low) - VW'(lc) : VW'(lh_s) - VW'(lc);

	// The negative half runs from the saturation end up to the dead zone edge.
	assign lmin = side_q ? satv_q : dzv_q;
	assign lmax = side_q ? dzv_q : satv_q;
	assign pmin = side_q ? 18'(cfg.output_low) : pc;
	assign pmax = side_q ? pc : 18'(cfg.output_high);
	assign cmp_low = MD_AW'(v_q) <= lmin;
	assign cmp_high = MD_AW'(v_q) >= lmax;
	assign ax_r = (MD_QW + 1)'(pmin) + (MD_QW + 1)'(md_rsp.q);

	assign raw = btn_q[TRIG_HIGH_BIT] ? 17'(TRIG_HIGH)
		: (btn_q[TRIG_LOW_BIT] ? 17'(TRIG_LOW) : 17'sd0);
	assign lin_d = lh_s - 18'(cfg.logical_low);
	assign lin_r = (MD_QW + 1)'(cfg.output_low) + (MD_QW + 1)'(md_rsp.q);

	assign out_free = !m_valid_q || m_tready;
	assign out_load = (state_q == C_EMIT) && out_free;

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		md_req = '0;
		unique case (state_q)
			C_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = C_AXIS;
			end
			C_AXIS: begin
				if (idx_q == 3'(AXES)) state_d = btn_chg_q ? C_BTN : C_HAT;
				else if (chg_q[idx_q[1:0]]) state_d = C_DZ_GO;
			end
			C_DZ_GO: begin
				md_req.start = 1'b1;
				md_req.a = MD_AW'(side_a);
				md_req.b = MD_BW'($signed({1'b0, cfg.dead_zone}));
				md_req.c = MD_CW'(PCT_SCALE);
				state_d = C_DZ_WAIT;
			end
			C_DZ_WAIT: if (md_rsp.done) state_d = C_SAT_GO;
			C_SAT_GO: begin
				md_req.start = 1'b1;
				md_req.a = MD_AW'(side_a);
				md_req.b = MD_BW'($signed({1'b0, cfg.saturation_point}));
				md_req.c = MD_CW'(PCT_SCALE);
				state_d = C_SAT_WAIT;
			end
			C_SAT_WAIT: if (md_rsp.done) state_d = C_CMP;
			C_CMP: begin
				if (cmp_low || cmp_high) begin
					state_d = C_EMIT;
				end else begin
					md_req.start = 1'b1;
					md_req.a = MD_AW'(v_q) - lmin;
					md_req.b = MD_BW'(pmax) - MD_BW'(pmin);
					md_req.c = lmax - lmin;
					state_d = C_DIV_WAIT;
				end
			end
			C_DIV_WAIT: if (md_rsp.done) state_d = C_EMIT;
			C_BTN: begin
				if (bidx_q == nb) state_d = xin ? C_TRIG : C_HAT;
				else state_d = C_EMIT;
			end
			C_TRIG: begin
				if (lin_d == 18'sd0) begin
					state_d = C_EMIT;
				end else begin
					md_req.start = 1'b1;
					md_req.a = MD_AW'(raw) - MD_AW'(cfg.logical_low);
					md_req.b = MD_BW'(cfg.output_high) - MD_BW'(cfg.output_low);
					md_req.c = MD_CW'(lin_d);
					state_d = C_TRIG_WAIT;
				end
			end
			C_TRIG_WAIT: if (md_rsp.done) state_d = C_EMIT;
			C_HAT: state_d = hat_chg_q ? C_EMIT : C_IDLE;
			C_EMIT: if (out_free) state_d = ret_q;
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= C_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) prev_ax_q[i] <= '0;
			prev_btn_q <= '0;
			prev_hat_q <= '0;
			count_q <= '0;
			chg_q <= '0;
			btn_chg_q <= 1'b0;
			hat_chg_q <= 1'b0;
			total_q <= '0;
			sent_q <= '0;
			idx_q <= '0;
			bidx_q <= '0;
			ret_q <= C_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == C_IDLE && s_tvalid) begin
				for (int i = 0; i < AXES; i++) prev_ax_q[i] <= in_ax[i];
				prev_btn_q <= s_tdata[79:64];
				prev_hat_q <= s_tdata[83:80];
				count_q <= count_q + 32'd1;
				chg_q <= in_chg;
				btn_chg_q <= in_btn_chg;
				hat_chg_q <= in_hat_chg;
				total_q <= in_total;
				sent_q <= '0;
				idx_q <= '0;
				bidx_q <= '0;
			end
			if (state_q == C_AXIS && idx_q != 3'(AXES) && !chg_q[idx_q[1:0]])
				idx_q <= idx_q + 3'd1;
			if (state_d == C_EMIT && state_q != C_EMIT) begin
				case (state_q)
					C_CMP, C_DIV_WAIT: begin
						ret_q <= C_AXIS;
						idx_q <= idx_q + 3'd1;
					end
					C_BTN: begin
						ret_q <= C_BTN;
						bidx_q <= bidx_q + 5'd1;
					end
					C_HAT: ret_q <= C_IDLE;
					default: ret_q <= C_HAT;
				endcase
			end
			if (out_load) begin
				sent_q <= sent_q + TW'(1);
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (s_tvalid) begin
					for (int i = 0; i < AXES; i++) item_ax_q[i] <= $signed(in_ax[i]);
					btn_q <= s_tdata[79:64];
					hat_q <= s_tdata[83:80];
					seq_q <= count_q;
				end
			end
			C_AXIS: begin
				v_q <= v_new;
				side_q <= v_new <= VW'(0);
				ev_kind_q <= EV_AXIS;
				ev_inst_q <= {1'b0, idx_q} + ((xin && idx_q >= 3'd2) ? 4'd1 : 4'd0);
			end
			C_DZ_WAIT: if (md_rsp.done) dzv_q <= md_rsp.q[MD_AW-1:0];
			C_SAT_WAIT: if (md_rsp.done) satv_q <= md_rsp.q[MD_AW-1:0];
			C_CMP: ev_val_q <= cmp_low ? pmin[16:0] : pmax[16:0];
			C_DIV_WAIT: if (md_rsp.done) ev_val_q <= ax_r[16:0];
			C_BTN: begin
				ev_kind_q <= EV_BUTTON;
				ev_inst_q <= xin ? bidx_q[3:0] : remap_std(bidx_q[3:0]);
				ev_val_q <= btn_q[bidx_q[3:0]] ? 17'(BUTTON_ON) : 17'd0;
			end
			C_TRIG: begin
				ev_kind_q <= EV_AXIS;
				ev_inst_q <= 4'd2;
				ev_val_q <= cfg.output_low;
			end
			C_TRIG_WAIT: begin
				if (md_rsp.done) begin
					if (lin_r > (MD_QW + 1)'(65535)) ev_val_q <= 17'h0FFFF;
					else if (lin_r < -(MD_QW + 1)'(65536)) ev_val_q <= 17'h10000;
					else ev_val_q <= lin_r[16:0];
				end
			end
			C_HAT: begin
				ev_kind_q <= EV_HAT;
				ev_inst_q <= 4'd0;
				ev_val_q <= hat_q[3] ? 17'h1FFFF : 17'(32'(hat_q[2:0]) * HAT_STEP);
			end
			default: ;
		endcase
		if (out_load) begin
			m_kind_q <= ev_kind_q;
			m_inst_q <= ev_inst_q;
			m_val_q <= ev_val_q;
			m_seq_q <= seq_q;
			m_last_q <= (sent_q + TW'(1)) == total_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {1'b0, m_seq_q, m_val_q, m_inst_q, m_kind_q};
	assign m_tlast = m_last_q;

endmodule

// File: design/gamepad_report_event_mapper_top.sv
// Work per report: each changed stick axis takes up to three multiply-divides (dead zone,
// saturation and scaling) and then its event, each button event is emitted in turn, and
// the trigger axis takes at most one multiply-divide; the input stays closed until the
// last event of the report is loaded into the output register.
// One report is worked at a time; the 43-step restoring divider sets the rate.
// Reset clears the stored report and the sequence count and loads register defaults.
module gamepad_report_event_mapper_top import gpem_pkg::*; #(
	parameter int STD_BUTTONS = DEF_STD_BUTTONS,
	parameter int XIN_BUTTONS = DEF_XIN_BUTTONS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [2:0]       cfg_index,
	input  logic [16:0]      cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// left_x, left_y, right_x, right_y, button_bits, hat_position, zero fill
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// event_kind, object_instance, event_value, sequence_number, zero fill
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tlast
);

	cfg_t    cfg_q;
	md_req_t md_req;
	md_rsp_t md_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= 1'b1;
			cfg_q.logical_low <= -16'sd32768;
			cfg_q.logical_high <= 15'd32767;
			cfg_q.output_low <= 17'sd0;
			cfg_q.output_high <= 17'sd65535;
			cfg_q.dead_zone <= 14'd0;
			cfg_q.saturation_point <= 14'd10000;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODE: cfg_q.mode <= cfg_data[0];
				REG_LOG_LOW: cfg_q.logical_low <= cfg_data[15:0];
				REG_LOG_HIGH: cfg_q.logical_high <= cfg_data[14:0];
				REG_OUT_LOW: cfg_q.output_low <= cfg_data;
				REG_OUT_HIGH: cfg_q.output_high <= cfg_data;
				REG_DEAD_ZONE: cfg_q.dead_zone <= cfg_data[13:0];
				REG_SATURATION: cfg_q.saturation_point <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	gpem_ctrl #(
		.STD_BUTTONS(STD_BUTTONS),
		.XIN_BUTTONS(XIN_BUTTONS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.md_req(md_req),
		.md_rsp(md_rsp)
	);

	gpem_muldiv u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.req(md_req),
		.rsp(md_rsp)
	);

endmodule

// File: design/gpem_checker.sv
module gpem_checker import gpem_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tlast
);

	// A stalled event keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("event changed while stalled");

	// A report is worked alone, so the input closes right after a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input open while a report is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == EV_HAT |-> m_tdata[5:2] == 4'd0)
		else $error("hat event on a nonzero instance");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == EV_BUTTON |-> m_tdata[22:6] == 17'd0 ||
			m_tdata[22:6] == 17'(BUTTON_ON))
		else $error("button event with a bad value");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("unknown event kind");

endmodule

bind gamepad_report_event_mapper_top gpem_checker u_chk (.*);

// File: tb/tb.sv
module tb;
	import gpem_pkg::*;

	typedef struct {
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic [15:0]        btn;
		logic [3:0]         hat;
	} report_t;

	typedef struct {
		ev_kind_t    kind;
		logic [3:0]  inst;
		logic [16:0] value;
		logic [31:0] seq;
		logic        last;
	} pad_event_t;

	logic             clk = 0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [2:0]       cfg_index;
	logic [16:0]      cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tlast;

	gamepad_report_event_mapper_top dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Predictor copy of the registers and the stored report.
	logic          mode_q;
	longint        log_low, log_high, out_low, out_high, dz_pct, sat_pct;
	logic [15:0]   last_axis [4];
	logic [15:0]   last_btn;
	logic [3:0]    last_hat;
	logic [31:0]   report_seq;

	pad_event_t    events_q[$];
	int            errors = 0;
	bit            quiet = 0;
	report_t       cur;

	function automatic longint mul_div_round(longint a, longint b, longint c);
		longint p;
		if (c < 0) begin
			a = -a;
			c = -c;
		end
		p = a * b;
		if ((a < 0) != (b < 0))
			return (p - c / 2) / c;
		return (p + c / 2) / c;
	endfunction

	function automatic longint centre_of(longint lo, longint hi);
		longint s;
		if (lo == 0)
			return hi >= 0 ? hi / 2 : -((-hi + 1) / 2);
		s = lo + hi;
		return s >= 0 ? (s + 1) / 2 : -((-s + 1) / 2);
	endfunction

	function automatic longint scale_stick(longint v);
		longint lmin, lmax, pmin, pmax, pc, lc;
		pmin = out_low;
		pmax = out_high;
		pc = centre_of(out_low, out_high);
		lc = centre_of(log_low, log_high);
		v -= lc;
		if (v <= 0) begin
			lmax = mul_div_round(log_low - lc, dz_pct, PCT_SCALE);
			lmin = mul_div_round(log_low - lc, sat_pct, PCT_SCALE);
			pmax = pc;
		end else begin
			lmin = mul_div_round(log_high - lc, dz_pct, PCT_SCALE);
			lmax = mul_div_round(log_high - lc, sat_pct, PCT_SCALE);
			pmin = pc;
		end
		if (v <= lmin) return pmin;
		if (v >= lmax) return pmax;
		return pmin + mul_div_round(v - lmin, pmax - pmin, lmax - lmin);
	endfunction

	function automatic longint scale_trigger(longint v);
		longint r;
		if (log_high == log_low) return out_low;
		r = out_low + mul_div_round(v - log_low, out_high - out_low, log_high - log_low);
		if (r > 65535) r = 65535;
		if (r < -65536) r = -65536;
		return r;
	endfunction

	function automatic void add_event(ev_kind_t k, int inst, longint val, logic [31:0] seq);
		pad_event_t e;
		e.kind = k;
		e.inst = inst[3:0];
		e.value = val[16:0];
		e.seq = seq;
		e.last = 0;
		events_q.push_back(e);
	endfunction

	function automatic void predict_events(report_t r);
		logic [15:0] ax [4];
		int          base, raw;
		logic [31:0] seq;
		seq = report_seq;
		report_seq++;
		base = events_q.size();
		ax[0] = r.lx;
		ax[1] = r.ly;
		ax[2] = r.rx;
		ax[3] = r.ry;
		for (int i = 0; i < 4; i++)
			if (ax[i] != last_axis[i]) begin
				last_axis[i] = ax[i];
				add_event(EV_AXIS, mode_q ? (i < 2 ? i : i + 1) : i,
					scale_stick(longint'($signed(ax[i]))), seq);
			end
		if (r.btn != last_btn) begin
			last_btn = r.btn;
			if (!mode_q) begin
				for (int i = 0; i < DEF_STD_BUTTONS; i++)
					add_event(EV_BUTTON, remap_table(i), r.btn[i] ? BUTTON_ON : 0, seq);
			end else begin
				for (int i = 0; i < DEF_XIN_BUTTONS; i++)
					add_event(EV_BUTTON, i, r.btn[i] ? BUTTON_ON : 0, seq);
				raw = r.btn[TRIG_HIGH_BIT] ? TRIG_HIGH : (r.btn[TRIG_LOW_BIT] ? TRIG_LOW : 0);
				add_event(EV_AXIS, 2, scale_trigger(raw), seq);
			end
		end
		if (r.hat != last_hat) begin
			last_hat = r.hat;
			add_event(EV_HAT, 0, $signed(r.hat) < 0 ? -1 : longint'(r.hat) * HAT_STEP, seq);
		end
		if (events_q.size() > base)
			events_q[events_q.size() - 1].last = 1;
	endfunction

	// Standard layout button order, kept as a table of its own.
	function automatic int remap_table(int i);
		int t [12] = '{1, 2, 0, 3, 4, 5, 8, 9, 10, 11, 6, 7};
		return i < 12 ? t[i] : i;
	endfunction

	task automatic send_report(report_t r);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {4'b0, r.hat, r.btn, r.ry, r.rx, r.ly, r.lx};
		do @(posedge clk); while (!s_tready);
		predict_events(r);
	endtask

	task automatic wait_idle();
		s_tvalid <= 0;
		while (events_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_regs(logic md, longint llo, longint lhi, longint olo, longint ohi,
			longint dz, longint sat);
		longint vals [7];
		wait_idle();
		vals = '{md, llo, lhi, olo, ohi, dz, sat};
		for (int i = 0; i < 7; i++) begin
			cfg_wr_en <= 1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= vals[i][16:0];
			@(posedge clk);
		end
		cfg_wr_en <= 0;
		mode_q = md;
		log_low = llo;
		log_high = lhi;
		out_low = olo;
		out_high = ohi;
		dz_pct = dz;
		sat_pct = sat;
	endtask

	function automatic report_t random_report(report_t prev);
		report_t r;
		r = prev;
		if ($urandom_range(0, 9) == 0) begin
			r.lx = 16'($urandom);
			r.ly = 16'($urandom);
			r.rx = 16'($urandom);
			r.ry = 16'($urandom);
			r.btn = 16'($urandom);
			r.hat = 4'($urandom);
			return r;
		end
		if ($urandom_range(0, 9) < 4) r.lx = 16'($urandom);
		if ($urandom_range(0, 9) < 4) r.ly = 16'($urandom);
		if ($urandom_range(0, 9) < 4) r.rx = 16'($urandom);
		if ($urandom_range(0, 9) < 4) r.ry = 16'($urandom);
		if ($urandom_range(0, 9) < 3) r.btn = 16'($urandom);
		if ($urandom_range(0, 9) < 3)
			r.hat = $urandom_range(0, 3) == 0 ? 4'hf : 4'($urandom_range(0, 7));
		if ($urandom_range(0, 19) == 0) r.hat = 4'($urandom);
		return r;
	endfunction

	task automatic send_fields(int lx, int ly, int rx, int ry, int btn, int hat);
		cur.lx = 16'(lx);
		cur.ly = 16'(ly);
		cur.rx = 16'(rx);
		cur.ry = 16'(ry);
		cur.btn = 16'(btn);
		cur.hat = 4'(hat);
		send_report(cur);
	endtask

	task automatic test_default_layout();
		send_fields(32767, -32768, 0, 1, 16'hffff, 7);
		send_fields(32767, -32768, 0, 1, 16'hffff, 7);
		send_fields(-1, 16384, -16384, -32767, 16'h0400, -1);
		send_fields(0, 0, 0, 0, 16'h0800, 0);
		send_fields(5, 5, 5, 5, 16'h0c00, -8);
	endtask

	task automatic test_standard_layout();
		write_regs(0, -32768, 32767, -65536, 65535, 2500, 7500);
		send_fields(32767, -32768, 100, -100, 16'h0000, 3);
		send_fields(32000, -32000, 20000, -20000, 16'haaaa, -1);
		send_fields(1, -1, 9000, -9000, 16'h5555, 1);
		write_regs(0, -32768, 32767, 65535, -65536, 9000, 1000);
		send_fields(32767, -32768, 10000, -10000, 16'hf000, 2);
		send_fields(1000, -1000, 0, 1, 16'h0fff, 4);
	endtask

	task automatic test_range_corners();
		write_regs(1, 0, 0, -65536, -65536, 10000, 0);
		send_fields(-5, 5, 32767, -32768, 16'h0400, 5);
		send_fields(0, 0, 0, 0, 16'h0800, 6);
		write_regs(1, -20000, 30000, -100, 65535, 0, 10000);
		send_fields(-20000, 30000, 5000, -19999, 16'h0000, 7);
		send_fields(32767, -32768, 4000, 6000, 16'h0c00, -2);
		write_regs(1, 0, 32767, 0, 100, 10000, 10000);
		send_fields(16383, 16384, 0, 32767, 16'h0400, 0);
	endtask

	task automatic test_random_reports();
		longint llo, lhi, olo, ohi;
		for (int ph = 0; ph < 6; ph++) begin
			llo = $urandom_range(0, 3) == 0 ? -32768 : -longint'($urandom_range(0, 32768));
			lhi = $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(0, 32767);
			olo = longint'($urandom_range(0, 131071)) - 65536;
			ohi = $urandom_range(0, 2) == 0 ? 65535 : longint'($urandom_range(0, 131071)) - 65536;
			if (ph == 5) quiet = 1;
			write_regs(1'($urandom_range(0, 1)), llo, lhi, olo, ohi,
				$urandom_range(0, 10000), $urandom_range(0, 10000));
			repeat (37) begin
				cur = random_report(cur);
				send_report(cur);
			end
		end
		wait_idle();
	endtask

	always @(posedge clk) begin
		pad_event_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (events_q.size() == 0) begin
				$error("unexpected event %h", m_tdata);
				errors++;
			end else begin
				e = events_q.pop_front();
				if (m_tdata[1:0] !== e.kind) begin
					$error("event_kind expected %0d got %0d", e.kind, m_tdata[1:0]);
					errors++;
				end
				if (m_tdata[5:2] !== e.inst) begin
					$error("object_instance expected %0d got %0d", e.inst, m_tdata[5:2]);
					errors++;
				end
				if (m_tdata[22:6] !== e.value) begin
					$error("event_value expected %0d got %0d", $signed(e.value),
						$signed(m_tdata[22:6]));
					errors++;
				end
				if (m_tdata[54:23] !== e.seq) begin
					$error("sequence_number expected %0d got %0d", e.seq, m_tdata[54:23]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last_of_run expected %0d got %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// Receiver stalls come in bursts until the final quiet phase.
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 13);
			m_tready <= 0;
		end else begin
			m_tready <= 1;
		end
	end

	initial begin
		arst_n <= 0;
		cfg_wr_en <= 0;
		cfg_index <= REG_MODE;
		cfg_data <= 0;
		s_tvalid <= 0;
		s_tdata <= 0;
		m_tready <= 0;
		mode_q = 1;
		log_low = -32768;
		log_high = 32767;
		out_low = 0;
		out_high = 65535;
		dz_pct = 0;
		sat_pct = 10000;
		foreach (last_axis[i]) last_axis[i] = 0;
		last_btn = 0;
		last_hat = 0;
		report_seq = 0;
		cur = '{0, 0, 0, 0, 0, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_default_layout();
		test_standard_layout();
		test_range_corners();
		test_random_reports();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#30000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
design/gpem_pkg.sv
design/gpem_muldiv.sv
design/gpem_ctrl.sv
design/gamepad_report_event_mapper_top.sv
design/gpem_checker.sv
tb/tb.sv
